// ----- rtl/core/grouped_team_fifo_queue_top_defines.svh -----
// Assertion macros for the team queue.
`ifndef GROUPED_TEAM_FIFO_QUEUE_TOP_DEFINES_SVH
`define GROUPED_TEAM_FIFO_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GTQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GTQ_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GTQ_ASSERT(lbl, prop, msg)
`define GTQ_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/core/gtq_pkg.sv -----
// Shared types and constants for the team queue.
`default_nettype none
package gtq_pkg;
    localparam int MAX_TEAMS      = 16;
    localparam int ELEMENT_IDS    = 4096;
    localparam int QUEUE_CAPACITY = 1024;

    localparam int TEAM_W   = 4;
    localparam int ELEM_W   = 12;
    localparam int SLOT_W   = 10;
    localparam int FREE_W   = 11;
    localparam int ORDCNT_W = 5;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_ENQUEUE = 2'd1;
    localparam logic [1:0] FUNC_DEQUEUE = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_ELEMENT = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } gtq_state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [ELEM_W-1:0] element_id;
        logic [TEAM_W-1:0] team_id;
    } gtq_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ELEM_W-1:0] element_out;
        logic [TEAM_W-1:0] team_out;
    } gtq_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/core/gtq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/grouped_team_fifo_queue_top.sv -----
// Team queue: membership table, linked element store and active-team ring.
//
// Requests enter on req (valid/ready); each produces exactly one response
// on rsp (valid/ready). func selects load membership, enqueue or dequeue.
// A request is handled in an accept cycle and then the exec state: the
// accept cycle issues the memory reads (membership, free stack, element
// and link of the front team's head), and the exec state writes back and
// loads the response register. One request is in work at a time, so no new
// request is taken until it finishes. rsp_valid_reg is set as it finishes.
// A new request is accepted while a finished response still waits; if the
// receiver stalls, the request in work holds its write-back until the
// response register frees up, and req_ready stays low meanwhile.
// After reset a clearing pass over all 4096 membership entries zeroes the
// membership table and loads the free stack with every slot; req_ready is low during it.
`default_nettype none
`include "grouped_team_fifo_queue_top_defines.svh"
module grouped_team_fifo_queue_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire gtq_pkg::gtq_req_t req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output gtq_pkg::gtq_rsp_t     rsp
);
    import gtq_pkg::*;

    localparam int MEMB_AW = $clog2(ELEMENT_IDS);

    gtq_state_t state_reg, state_next;
    gtq_req_t   req_reg;
    gtq_rsp_t   rsp_reg, rsp_next;
    logic       rsp_valid_reg;

    logic [MEMB_AW-1:0]  clr_cnt_reg;
    logic [FREE_W-1:0]   free_count_reg;
    logic [TEAM_W-1:0]   order_head_reg;
    logic [ORDCNT_W-1:0] order_count_reg;
    logic                waiting_reg [MAX_TEAMS];
    logic [SLOT_W-1:0]   team_head_reg [MAX_TEAMS];
    logic [SLOT_W-1:0]   team_tail_reg [MAX_TEAMS];
    logic [TEAM_W-1:0]   active_order_reg [MAX_TEAMS];

    logic accept, finish, clearing;

    // memory ports
    logic                memb_we, free_we, elem_we, link_we;
    logic [MEMB_AW-1:0]  memb_waddr;
    logic [TEAM_W-1:0]   memb_wdata, memb_rdata;
    logic [SLOT_W-1:0]   free_waddr, free_wdata, free_raddr, free_rdata;
    logic [SLOT_W-1:0]   elem_waddr, link_waddr, link_wdata, link_rdata, deq_slot;
    logic [ELEM_W-1:0]   elem_rdata;

    // exec-cycle decode
    logic              is_enq, is_deq, is_load, enq_ok, deq_ok, deq_last;
    logic [TEAM_W-1:0] enq_team, deq_team, order_tail;

    assign clearing  = (state_reg == ST_CLEAR);
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign finish    = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign deq_team   = active_order_reg[order_head_reg];
    assign deq_slot   = team_head_reg[deq_team];
    assign enq_team   = memb_rdata;
    assign order_tail = order_head_reg + order_count_reg[TEAM_W-1:0];
    assign free_raddr = free_count_reg[SLOT_W-1:0] - SLOT_W'(1);

    assign is_load  = (req_reg.func == FUNC_LOAD);
    assign is_enq   = (req_reg.func == FUNC_ENQUEUE);
    assign is_deq   = (req_reg.func == FUNC_DEQUEUE);
    assign enq_ok   = is_enq && (free_count_reg != '0);
    assign deq_ok   = is_deq && (order_count_reg != '0);
    assign deq_last = (deq_slot == team_tail_reg[deq_team]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == MEMB_AW'(ELEMENT_IDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory writes and response
    always_comb
    begin
        memb_we    = 1'b0;
        memb_waddr = req_reg.element_id[MEMB_AW-1:0];
        memb_wdata = req_reg.team_id;
        free_we    = 1'b0;
        free_waddr = free_count_reg[SLOT_W-1:0];
        free_wdata = deq_slot;
        elem_we    = 1'b0;
        elem_waddr = free_rdata;
        link_we    = 1'b0;
        link_waddr = team_tail_reg[enq_team];
        link_wdata = free_rdata;
        rsp_next   = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                memb_we    = 1'b1;
                memb_waddr = clr_cnt_reg;
                memb_wdata = '0;
                free_we    = (clr_cnt_reg < MEMB_AW'(QUEUE_CAPACITY));
                free_waddr = clr_cnt_reg[SLOT_W-1:0];
                free_wdata = clr_cnt_reg[SLOT_W-1:0];
            end
            ST_EXEC:
            begin
                memb_we = finish && is_load;
                elem_we = finish && enq_ok;
                link_we = finish && enq_ok && waiting_reg[enq_team];
                free_we = finish && deq_ok && (free_count_reg < FREE_W'(QUEUE_CAPACITY));
                if (is_enq && !enq_ok)
                begin
                    rsp_next.status = STATUS_FULL;
                end
                else if (is_deq && !deq_ok)
                begin
                    rsp_next.status = STATUS_EMPTY;
                end
                else if (deq_ok)
                begin
                    rsp_next.status      = STATUS_ELEMENT;
                    rsp_next.element_out = elem_rdata;
                    rsp_next.team_out    = deq_team;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            rsp_valid_reg   <= 1'b0;
            free_count_reg  <= FREE_W'(QUEUE_CAPACITY);
            order_head_reg  <= '0;
            order_count_reg <= '0;
            for (int i = 0; i < MAX_TEAMS; i++)
            begin
                waiting_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEMB_AW'(1);
            end
            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (finish && enq_ok)
            begin
                free_count_reg <= free_count_reg - FREE_W'(1);
                if (!waiting_reg[enq_team])
                begin
                    waiting_reg[enq_team] <= 1'b1;
                    if (order_count_reg < ORDCNT_W'(MAX_TEAMS))
                    begin
                        order_count_reg <= order_count_reg + ORDCNT_W'(1);
                    end
                end
            end
            if (finish && deq_ok)
            begin
                if (free_count_reg < FREE_W'(QUEUE_CAPACITY))
                begin
                    free_count_reg <= free_count_reg + FREE_W'(1);
                end
                if (deq_last)
                begin
                    waiting_reg[deq_team] <= 1'b0;
                    order_head_reg        <= order_head_reg + TEAM_W'(1);
                    order_count_reg       <= order_count_reg - ORDCNT_W'(1);
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (finish)
        begin
            rsp_reg <= rsp_next;
        end
        if (finish && enq_ok)
        begin
            team_tail_reg[enq_team] <= free_rdata;
            if (!waiting_reg[enq_team])
            begin
                team_head_reg[enq_team] <= free_rdata;
                if (order_count_reg < ORDCNT_W'(MAX_TEAMS))
                begin
                    active_order_reg[order_tail] <= enq_team;
                end
            end
        end
        if (finish && deq_ok && !deq_last)
        begin
            team_head_reg[deq_team] <= link_rdata;
        end
    end

    gtq_ram #(.WIDTH(TEAM_W), .DEPTH(ELEMENT_IDS)) u_memb (
        .clk   (clk),
        .we    (memb_we),
        .waddr (memb_waddr),
        .wdata (memb_wdata),
        .re    (accept),
        .raddr (req.element_id[MEMB_AW-1:0]),
        .rdata (memb_rdata)
    );

    gtq_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_CAPACITY)) u_free (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .re    (accept),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    gtq_ram #(.WIDTH(ELEM_W), .DEPTH(QUEUE_CAPACITY)) u_elem (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (req_reg.element_id),
        .re    (accept),
        .raddr (deq_slot),
        .rdata (elem_rdata)
    );

    gtq_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_CAPACITY)) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (accept),
        .raddr (deq_slot),
        .rdata (link_rdata)
    );

    `GTQ_ASSERT(a_free_range, free_count_reg <= FREE_W'(QUEUE_CAPACITY), "free count overflow")
    `GTQ_ASSERT(a_order_range, order_count_reg <= ORDCNT_W'(MAX_TEAMS), "order count overflow")
    `GTQ_ASSERT(a_accept_exec, accept |=> (state_reg == ST_EXEC), "request not executed")
    `GTQ_ASSERT_NEVER(a_clear_ready, clearing && req_ready, "ready during clear")
endmodule
`default_nettype wire
